>>> hw/rtl/edf_pkg.sv
// Shared constants and control types for the earliest-deadline-first job queue.
// Used by edf_ctrl, edf_datapath and edf_job_queue_core; depends on nothing else.

package edf_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int ID_W = 16;
    localparam int CT_W = 16;
    localparam int DL_W = 32;

    // Input item kinds
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture the accepted transaction
        logic scan_clr;   // restart the insertion scan at the head
        logic scan_step;  // move the insertion scan one entry on
        logic commit;     // update the queue and load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic lat_tick;   // captured transaction is a scheduler tick
        logic lat_bad;    // captured add has a zero id or zero compute time
        logic full;       // queue holds QUEUE_DEPTH jobs
        logic scan_more;  // entry under the scan sorts ahead of the new job
    } t_dp_status;

endpackage

>>> hw/rtl/edf_ctrl.sv
// Controller of the job queue: sequences decode, insertion scan and commit,
// and owns both handshakes. Depends on edf_pkg.

module edf_ctrl
    import edf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    // Result slot can take a new result when empty or being drained
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Decode state into datapath commands and the next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_status.lat_tick && !i_status.lat_bad && !i_status.full) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SCAN: begin
                if (i_status.scan_more) begin
                    o_cmd.scan_step = 1'b1;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Raise output valid on commit, drop it once the transaction is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Hold state and the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // A commit never overwrites a result that is still waiting
    a_commit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> slot_free)
        else $error("commit while result slot occupied");

    // Output valid only rises after a commit
    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.commit))
        else $error("output valid without commit");

endmodule

>>> hw/rtl/edf_datapath.sv
// Datapath of the job queue: sorted job entries, occupancy, insertion scan
// pointer, captured transaction and result register. Depends on edf_pkg.

module edf_datapath
    import edf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_mode,
    input  logic [ID_W-1:0]  i_job_id,
    input  logic [CT_W-1:0]  i_compute_time,
    input  logic [DL_W-1:0]  i_deadline,
    input  t_dp_cmd          i_cmd,
    output t_dp_status       o_status,
    output logic [ID_W-1:0]  o_running_id,
    output logic             o_job_finished,
    output logic             o_add_dropped
);

    // Job entries, head at index 0
    logic [ID_W-1:0]  r_ids       [QUEUE_DEPTH];
    logic [CT_W-1:0]  r_remaining [QUEUE_DEPTH];
    logic [DL_W-1:0]  r_deadlines [QUEUE_DEPTH];

    logic [CNT_W-1:0] r_occ;
    logic [CNT_W-1:0] n_occ;
    logic [CNT_W-1:0] r_ptr;
    logic [CNT_W-1:0] n_ptr;

    // Captured transaction
    logic             r_mode;
    logic [ID_W-1:0]  r_id;
    logic [CT_W-1:0]  r_ct;
    logic [DL_W-1:0]  r_dl;

    // Result register
    logic [ID_W-1:0]  r_res_id;
    logic             r_res_fin;
    logic             r_res_drop;

    logic             full;
    logic             empty;
    logic             lat_bad;
    logic [CT_W-1:0]  head_rem;
    logic             head_fin;
    logic             do_insert;
    logic             do_tick;

    assign full     = (r_occ == CNT_W'(QUEUE_DEPTH));
    assign empty    = (r_occ == '0);
    assign lat_bad  = (r_id == '0) || (r_ct == '0);
    assign head_rem = r_remaining[0] - CT_W'(1);
    assign head_fin = (head_rem == '0);

    assign do_insert = i_cmd.commit && (r_mode == MODE_ADD) && !lat_bad && !full;
    assign do_tick   = i_cmd.commit && (r_mode == MODE_TICK) && !empty;

    // Status towards the controller
    always_comb begin
        o_status.lat_tick  = (r_mode == MODE_TICK);
        o_status.lat_bad   = lat_bad;
        o_status.full      = full;
        o_status.scan_more = (r_ptr < r_occ) &&
                             (r_deadlines[r_ptr[IDX_W-1:0]] <= r_dl);
    end

    // Next occupancy and scan pointer
    always_comb begin
        n_occ = r_occ;
        if (do_insert) begin
            n_occ = r_occ + CNT_W'(1);
        end else if (do_tick && head_fin) begin
            n_occ = r_occ - CNT_W'(1);
        end
        n_ptr = r_ptr;
        if (i_cmd.scan_clr) begin
            n_ptr = '0;
        end else if (i_cmd.scan_step) begin
            n_ptr = r_ptr + CNT_W'(1);
        end
    end

    // Hold occupancy and scan pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
            r_ptr <= '0;
        end else begin
            r_occ <= n_occ;
            r_ptr <= n_ptr;
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_id   <= i_job_id;
            r_ct   <= i_compute_time;
            r_dl   <= i_deadline;
        end
    end

    // Insert behind the scan point, or advance the head on a tick
    always_ff @(posedge i_clk) begin
        if (do_insert) begin
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
                if (CNT_W'(k) == r_ptr) begin
                    r_ids[k]       <= r_id;
                    r_remaining[k] <= r_ct;
                    r_deadlines[k] <= r_dl;
                end else if ((k > 0) && (CNT_W'(k) > r_ptr)) begin
                    r_ids[k]       <= r_ids[k-1];
                    r_remaining[k] <= r_remaining[k-1];
                    r_deadlines[k] <= r_deadlines[k-1];
                end
            end
        end else if (do_tick) begin
            if (head_fin) begin
                for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                    r_ids[k]       <= r_ids[k+1];
                    r_remaining[k] <= r_remaining[k+1];
                    r_deadlines[k] <= r_deadlines[k+1];
                end
            end else begin
                r_remaining[0] <= head_rem;
            end
        end
    end

    // Load the result register on commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_id   <= do_tick ? r_ids[0] : '0;
            r_res_fin  <= do_tick && head_fin;
            r_res_drop <= (r_mode == MODE_ADD) && !lat_bad && full;
        end
    end

    assign o_running_id   = r_res_id;
    assign o_job_finished = r_res_fin;
    assign o_add_dropped  = r_res_drop;

    // Occupancy never exceeds the queue depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    // The scan never runs past the stored jobs
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step |-> (r_ptr < r_occ))
        else $error("scan stepped past occupancy");

    // Stored ids are never zero, so a tick on a busy queue reports a job
    a_tick_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_tick |=> (r_res_id != '0))
        else $error("tick reported idle id on busy queue");

endmodule

>>> hw/rtl/edf_job_queue_core.sv
// Top level of the earliest-deadline-first job queue.
// Instantiates edf_ctrl and edf_datapath; depends on edf_pkg.

// The queue keeps up to QUEUE_DEPTH (16) jobs sorted by ascending deadline,
// with equal deadlines in arrival order. One transaction is in work at a time.
// A tick, an add with a zero id or compute time, and an add to a full queue
// go from decode straight to the finish step. A stored add first scans past
// the k (at most QUEUE_DEPTH - 1) stored jobs whose deadline is less than or
// equal to the new one; the insertion scan compares one stored deadline per
// cycle. A new transaction is accepted while the previous result still waits
// in the output register; the final step of the next one waits until that
// result has been taken.

module edf_job_queue_core
    import edf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_mode,
    input  logic [ID_W-1:0]  i_job_id,
    input  logic [CT_W-1:0]  i_compute_time,
    input  logic [DL_W-1:0]  i_deadline,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [ID_W-1:0]  o_running_id,
    output logic             o_job_finished,
    output logic             o_add_dropped
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencing and handshakes
    edf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Job storage and result
    edf_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (i_mode),
        .i_job_id       (i_job_id),
        .i_compute_time (i_compute_time),
        .i_deadline     (i_deadline),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_running_id   (o_running_id),
        .o_job_finished (o_job_finished),
        .o_add_dropped  (o_add_dropped)
    );

endmodule

>>> bench/edf_job_queue_core_test.sv
// Self-checking bench for edf_job_queue_core: directed and random add and tick transactions.
// Depends on edf_pkg and the queue RTL; a scoreboard class mirrors the deadline-sorted queue.

module edf_job_queue_core_test;
    import edf_pkg::*;

    // One result transaction as it leaves the block
    typedef struct packed {
        logic [ID_W-1:0] running_id;
        logic            job_finished;
        logic            add_dropped;
    } t_job_outcome;

    // Mirror of the job queue plus the results still owed by the block
    class edf_scoreboard;
        logic [ID_W-1:0] queued_ids[QUEUE_DEPTH];
        logic [CT_W-1:0] queued_left[QUEUE_DEPTH];
        logic [DL_W-1:0] queued_deadlines[QUEUE_DEPTH];
        int unsigned     queued_jobs;
        t_job_outcome    awaited[$];
        int unsigned     failures;

        // Apply an accepted transaction to the mirror and queue its outcome
        function void admit_transaction(logic mode, logic [ID_W-1:0] id,
                                        logic [CT_W-1:0] ct, logic [DL_W-1:0] dl);
            t_job_outcome outcome;
            int unsigned  slot;
            int unsigned  k;
            outcome = '0;
            if (mode == MODE_ADD) begin
                // a zero id or zero compute time leaves everything untouched
                if (id != '0 && ct != '0) begin
                    if (queued_jobs >= QUEUE_DEPTH) begin
                        outcome.add_dropped = 1'b1;
                    end else begin
                        // go behind every job with an earlier or equal deadline
                        slot = 0;
                        while (slot < queued_jobs && queued_deadlines[slot] <= dl)
                            slot++;
                        for (k = queued_jobs; k > slot; k--) begin
                            queued_ids[k]       = queued_ids[k-1];
                            queued_left[k]      = queued_left[k-1];
                            queued_deadlines[k] = queued_deadlines[k-1];
                        end
                        queued_ids[slot]       = id;
                        queued_left[slot]      = ct;
                        queued_deadlines[slot] = dl;
                        queued_jobs++;
                    end
                end
            end else if (queued_jobs != 0) begin
                // run the head job for one tick, retire it when its time is used up
                outcome.running_id = queued_ids[0];
                queued_left[0] = queued_left[0] - 1'b1;
                if (queued_left[0] == '0) begin
                    outcome.job_finished = 1'b1;
                    for (k = 1; k < queued_jobs; k++) begin
                        queued_ids[k-1]       = queued_ids[k];
                        queued_left[k-1]      = queued_left[k];
                        queued_deadlines[k-1] = queued_deadlines[k];
                    end
                    queued_jobs--;
                end
            end
            awaited.push_back(outcome);
        endfunction

        // Compare a result transaction with the oldest outstanding outcome
        function void check_outcome(t_job_outcome got);
            t_job_outcome want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result running_id %h finished %b dropped %b",
                         $time, got.running_id, got.job_finished, got.add_dropped);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (got.running_id !== want.running_id) begin
                $display("%0t: running_id expected %h actual %h",
                         $time, want.running_id, got.running_id);
                failures++;
            end
            if (got.job_finished !== want.job_finished) begin
                $display("%0t: job_finished expected %b actual %b",
                         $time, want.job_finished, got.job_finished);
                failures++;
            end
            if (got.add_dropped !== want.add_dropped) begin
                $display("%0t: add_dropped expected %b actual %b",
                         $time, want.add_dropped, got.add_dropped);
                failures++;
            end
        endfunction
    endclass

    logic            i_clk          = 1'b0;
    logic            i_rst_n        = 1'b0;
    logic            i_in_valid     = 1'b0;
    logic            o_in_ready;
    logic            i_mode         = MODE_ADD;
    logic [ID_W-1:0] i_job_id       = '0;
    logic [CT_W-1:0] i_compute_time = '0;
    logic [DL_W-1:0] i_deadline     = '0;
    logic            o_out_valid;
    logic            i_out_ready    = 1'b0;
    logic [ID_W-1:0] o_running_id;
    logic            o_job_finished;
    logic            o_add_dropped;

    edf_scoreboard sched_board;

    // Idling percentages for the current phase
    int unsigned send_idle_pct = 0;
    int unsigned take_stall_pct = 0;
    // Long receiver hold-off: requests raised by the stimulus, served by the receiver
    int unsigned hold_asks = 0;
    int unsigned hold_taken = 0;
    int unsigned hold_left = 0;
    // Jobs with long compute times park in the queue, so allow only a few
    int unsigned long_jobs_left = 3;

    edf_job_queue_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_job_id       (i_job_id),
        .i_compute_time (i_compute_time),
        .i_deadline     (i_deadline),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_running_id   (o_running_id),
        .o_job_finished (o_job_finished),
        .o_add_dropped  (o_add_dropped)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAIL edf_job_queue_core");
        $finish;
    end

    // Receiver: check each result transaction, then choose next cycle's ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sched_board.check_outcome('{o_running_id, o_job_finished, o_add_dropped});
        if (hold_asks != hold_taken) begin
            hold_taken = hold_asks;
            hold_left  = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= take_stall_pct);
        end
    end

    // Offer one transaction, idling beforehand at the phase's rate, and wait for acceptance
    task automatic send_item(logic mode, logic [ID_W-1:0] id, logic [CT_W-1:0] ct,
                             logic [DL_W-1:0] dl);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_job_id       <= id;
        i_compute_time <= ct;
        i_deadline     <= dl;
        do @(posedge i_clk); while (!o_in_ready);
        sched_board.admit_transaction(mode, id, ct, dl);
    endtask

    // Random traffic in bursts whose tick share swings the queue between empty and full
    task automatic run_random(int unsigned items);
        int unsigned     n;
        int unsigned     tick_pct;
        int unsigned     pick;
        logic [ID_W-1:0] id;
        logic [CT_W-1:0] ct;
        logic [DL_W-1:0] dl;
        tick_pct = 50;
        for (n = 0; n < items; n++) begin
            if (n % 24 == 0) begin
                case ($urandom_range(3))
                    0: tick_pct = 25;
                    1: tick_pct = 45;
                    2: tick_pct = 55;
                    default: tick_pct = 72;
                endcase
            end
            if ($urandom_range(99) < tick_pct) begin
                // payload is ignored on a tick, so let every bit toggle
                send_item(MODE_TICK, ID_W'($urandom), CT_W'($urandom), $urandom);
            end else begin
                id = ($urandom_range(99) < 2) ? '0 : ID_W'($urandom_range(65535, 1));
                pick = $urandom_range(99);
                if (pick < 70)
                    ct = CT_W'($urandom_range(3, 1));
                else if (pick < 97)
                    ct = CT_W'($urandom_range(12, 1));
                else if (pick < 99)
                    ct = '0;
                else if (long_jobs_left > 0) begin
                    long_jobs_left--;
                    ct = CT_W'($urandom_range(65535, 1));
                end else
                    ct = CT_W'($urandom_range(3, 1));
                // mostly a narrow range so that equal deadlines are common
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: dl = $urandom_range(31);
                    5:       dl = $urandom_range(3);
                    6:       dl = $urandom;
                    7:       dl = '0;
                    8:       dl = '1;
                    default: dl = $urandom_range(300);
                endcase
                send_item(MODE_ADD, id, ct, dl);
            end
        end
    endtask

    initial begin
        int unsigned n;
        sched_board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty tick, ignored adds, extremes, ties, finishing and a full queue
        send_item(MODE_TICK, 16'h1234, 16'h0001, 32'h0000_0010);
        send_item(MODE_ADD, 16'h0000, 16'h0005, 32'h0000_0010);
        send_item(MODE_ADD, 16'h0005, 16'h0000, 32'h0000_0010);
        send_item(MODE_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(MODE_ADD, 16'h0001, 16'h0001, 32'h0000_0000);
        send_item(MODE_ADD, 16'h0002, 16'h0002, 32'h0000_0000);
        send_item(MODE_ADD, 16'h0003, 16'h0001, 32'h0000_0064);
        send_item(MODE_TICK, 16'h0000, 16'h0000, 32'h0000_0000);
        send_item(MODE_TICK, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(MODE_TICK, 16'h0000, 16'h0000, 32'h0000_0000);
        send_item(MODE_TICK, 16'h0000, 16'h0000, 32'h0000_0000);
        for (n = 0; n < 15; n++)
            send_item(MODE_ADD, ID_W'(16'h0100 + n), CT_W'(1 + n % 3),
                      DL_W'(1000 - (n / 2) * 50));
        send_item(MODE_ADD, 16'hBEEF, 16'h0001, 32'h0000_0005);

        // Back to back, with one long receiver hold-off to fill the block
        hold_asks++;
        run_random(480);
        send_idle_pct = 86;
        run_random(480);
        send_idle_pct  = 0;
        take_stall_pct = 86;
        run_random(480);
        send_idle_pct  = 16;
        take_stall_pct = 16;
        run_random(480);

        // Drain every outstanding result, then let the block settle
        i_in_valid     <= 1'b0;
        take_stall_pct = 0;
        while (sched_board.awaited.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sched_board.failures == 0 && sched_board.awaited.size() == 0)
            $display("PASS edf_job_queue_core");
        else
            $display("FAIL edf_job_queue_core");
        $finish;
    end

endmodule
